/* rtl/rdc_pkg.sv */
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared types and constants for the range distinct-count block.
// ----------------------------------------------------------------------------
package rdc_pkg;

  localparam int POS_W      = 10;
  localparam int VAL_W      = 10;
  localparam int CNT_W      = 11;
  localparam int MAX_POS    = 2 ** POS_W;
  localparam int MAX_COLORS = 2 ** VAL_W;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_SKIP  = 2'd1,
    OP_CONST = 2'd2,
    OP_QUERY = 2'd3
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t          op;
    logic [POS_W-1:0] pos_a;
    logic [POS_W-1:0] pos_b;
    logic [VAL_W-1:0] value;
    logic             bad;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             bad;
  } res_t;

endpackage

/* rtl/rdc_ram.sv */
// ----------------------------------------------------------------------------
// rdc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rdc_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/rdc_fifo.sv */
// ----------------------------------------------------------------------------
// rdc_fifo
// Small register-based queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module rdc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt;
  logic [PW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign dout    = mem_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= din;
    end
  end

endmodule

/* rtl/rdc_front.sv */
// ----------------------------------------------------------------------------
// rdc_front
// Accepts input transactions, classifies them into commands and queues them.
// ----------------------------------------------------------------------------
module rdc_front import rdc_pkg::*; #(
  parameter int ARRAY_SIZE  = 1024,
  parameter int COLOR_COUNT = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  logic             in_func,
  input  logic [POS_W-1:0] in_position,
  input  logic [VAL_W-1:0] in_color_value,
  input  logic [POS_W-1:0] in_range_lo,
  input  logic [POS_W-1:0] in_range_hi,
  input  logic             init_busy,
  output cmd_t             cmd,
  output logic             cmd_valid,
  input  logic             cmd_pop
);

  localparam int POS_LIM = (ARRAY_SIZE < MAX_POS) ? ARRAY_SIZE : MAX_POS;
  localparam int COL_LIM = (COLOR_COUNT < MAX_COLORS) ? COLOR_COUNT : MAX_COLORS;
  localparam logic [POS_W-1:0] LAST_POS   = POS_W'(POS_LIM - 1);
  localparam logic [VAL_W-1:0] LAST_COLOR = VAL_W'(COL_LIM - 1);

  cmd_t             cmd_in;
  logic [POS_W-1:0] hi_clamp;
  logic             q_full, q_empty;
  logic [$bits(cmd_t)-1:0] q_dout;

  always_comb begin
    cmd_in       = '0;
    hi_clamp     = (in_range_hi > LAST_POS) ? LAST_POS : in_range_hi;
    if (!in_func) begin
      cmd_in.op    = (in_position <= LAST_POS) ? OP_WRITE : OP_SKIP;
      cmd_in.pos_a = in_position;
      cmd_in.value = (in_color_value > LAST_COLOR) ? LAST_COLOR : in_color_value;
    end else if (in_range_lo > in_range_hi) begin
      cmd_in.op  = OP_CONST;
      cmd_in.bad = 1'b1;
    end else if (in_range_lo > hi_clamp) begin
      cmd_in.op = OP_CONST;
    end else begin
      cmd_in.op    = OP_QUERY;
      cmd_in.pos_a = in_range_lo;
      cmd_in.pos_b = hi_clamp;
    end
  end

  assign in_full   = q_full || init_busy;
  assign cmd_valid = !q_empty;
  assign cmd       = cmd_t'(q_dout);

  rdc_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (2)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push && !in_full),
    .din   (cmd_in),
    .full  (q_full),
    .pop   (cmd_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

endmodule

/* rtl/rdc_back.sv */
// ----------------------------------------------------------------------------
// rdc_back
// Executes commands: array writes, constant answers, and two-pass mark-and-clear range queries.
// ----------------------------------------------------------------------------
module rdc_back import rdc_pkg::*; #(
  parameter int ARRAY_SIZE  = 1024,
  parameter int COLOR_COUNT = 1024
) (
  input  logic clk,
  input  logic rst_n,
  input  cmd_t cmd,
  input  logic cmd_valid,
  output logic cmd_pop,
  output res_t res,
  output logic res_push,
  input  logic res_full,
  output logic init_busy
);

  localparam int STORE_DEPTH = (ARRAY_SIZE < MAX_POS) ? ARRAY_SIZE : MAX_POS;
  localparam int SEEN_DEPTH  = (COLOR_COUNT < MAX_COLORS) ? COLOR_COUNT : MAX_COLORS;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int CW          = $clog2(SEEN_DEPTH);
  localparam int INIT_LEN    = (STORE_DEPTH > SEEN_DEPTH) ? STORE_DEPTH : SEEN_DEPTH;
  localparam int IW          = $clog2(INIT_LEN);

  typedef enum logic [3:0] {
    ST_INIT  = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_MARK  = 4'b0100,
    ST_CLEAR = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [IW-1:0]    clr_r, clr_nxt;
  logic [POS_W-1:0] idx_r, idx_nxt;
  logic [POS_W-1:0] lo_r, lo_nxt;
  logic [POS_W-1:0] hi_r, hi_nxt;
  logic             issue_r, issue_nxt;
  logic             v1_r, v1_nxt;
  logic             v2_r, v2_nxt;
  logic             v3_r, v3_nxt;
  logic [CW-1:0]    c2_r, c2_nxt;
  logic [CW-1:0]    c3_r, c3_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic          e_we;
  logic [AW-1:0] e_waddr, e_raddr;
  logic [CW-1:0] e_wdata, e_rdata;
  logic          s_we, s_wdata, s_rdata, seen_bit;
  logic [CW-1:0] s_waddr, s_raddr;

  assign init_busy = (state_r == ST_INIT);

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    idx_nxt   = idx_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    issue_nxt = issue_r;
    v1_nxt    = 1'b0;
    v2_nxt    = 1'b0;
    v3_nxt    = 1'b0;
    c2_nxt    = c2_r;
    c3_nxt    = c3_r;
    cnt_nxt   = cnt_r;
    e_we      = 1'b0;
    e_waddr   = '0;
    e_wdata   = '0;
    e_raddr   = idx_r[AW-1:0];
    s_we      = 1'b0;
    s_waddr   = '0;
    s_wdata   = 1'b0;
    s_raddr   = e_rdata;
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    res.count = cnt_r;
    res.bad   = 1'b0;
    // A mark written in the previous cycle is not yet visible to this read.
    seen_bit  = s_rdata || (v3_r && (c3_r == c2_r));

    case (state_r)
      ST_INIT: begin
        e_we    = ({1'b0, clr_r} < (IW + 1)'(STORE_DEPTH));
        e_waddr = clr_r[AW-1:0];
        s_we    = ({1'b0, clr_r} < (IW + 1)'(SEEN_DEPTH));
        s_waddr = clr_r[CW-1:0];
        if (clr_r == IW'(INIT_LEN - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            OP_WRITE: begin
              e_we    = 1'b1;
              e_waddr = cmd.pos_a[AW-1:0];
              e_wdata = cmd.value[CW-1:0];
              cmd_pop = 1'b1;
            end
            OP_SKIP: begin
              cmd_pop = 1'b1;
            end
            OP_CONST: begin
              if (!res_full) begin
                res_push  = 1'b1;
                res.count = '0;
                res.bad   = cmd.bad;
                cmd_pop   = 1'b1;
              end
            end
            OP_QUERY: begin
              if (!res_full) begin
                cmd_pop   = 1'b1;
                idx_nxt   = cmd.pos_a;
                lo_nxt    = cmd.pos_a;
                hi_nxt    = cmd.pos_b;
                issue_nxt = 1'b1;
                cnt_nxt   = '0;
                state_nxt = ST_MARK;
              end
            end
            default: begin
              cmd_pop = 1'b1;
            end
          endcase
        end
      end
      ST_MARK: begin
        if (issue_r) begin
          v1_nxt = 1'b1;
          if (idx_r == hi_r) begin
            issue_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
        if (v1_r) begin
          c2_nxt = e_rdata;
          v2_nxt = 1'b1;
        end
        if (v2_r) begin
          v3_nxt = 1'b1;
          c3_nxt = c2_r;
          if (!seen_bit) begin
            s_we    = 1'b1;
            s_waddr = c2_r;
            s_wdata = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        if (!issue_r && !v1_r && !v2_r) begin
          idx_nxt   = lo_r;
          issue_nxt = 1'b1;
          state_nxt = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        if (issue_r) begin
          v1_nxt = 1'b1;
          if (idx_r == hi_r) begin
            issue_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
        if (v1_r) begin
          s_we    = 1'b1;
          s_waddr = e_rdata;
          s_wdata = 1'b0;
        end
        if (!issue_r && !v1_r) begin
          res_push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      clr_r   <= '0;
      issue_r <= 1'b0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      issue_r <= issue_nxt;
      v1_r    <= v1_nxt;
      v2_r    <= v2_nxt;
      v3_r    <= v3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    c2_r  <= c2_nxt;
    c3_r  <= c3_nxt;
    cnt_r <= cnt_nxt;
  end

  rdc_ram #(
    .WIDTH (CW),
    .DEPTH (STORE_DEPTH)
  ) u_elem_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  rdc_ram #(
    .WIDTH (1),
    .DEPTH (SEEN_DEPTH)
  ) u_seen_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

endmodule

/* rtl/range_distinct_count_with_updates.sv */
// ----------------------------------------------------------------------------
// range_distinct_count_with_updates
// Array of color values with point writes and distinct-count range queries.
//
// After reset the block sweeps its memories to zero over max(min(ARRAY_SIZE,
// 1024), min(COLOR_COUNT, 1024)) addresses, 1024 with the default
// parameters, and holds in_full high meanwhile. The engine handles a write
// transaction, and answers a reversed or empty range, in its idle state
// without walking the memories. For a query the engine walks the range once
// through the element memory and the seen-mark memory to count new values
// and then walks it again to clear the marks, one position per cycle on each
// memory port. A two-entry command queue in front and a two-entry result
// queue behind let both sides stall independently.
// ----------------------------------------------------------------------------
module range_distinct_count_with_updates import rdc_pkg::*; #(
  parameter int ARRAY_SIZE  = 1024,
  parameter int COLOR_COUNT = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  logic             in_func,
  input  logic [POS_W-1:0] in_position,
  input  logic [VAL_W-1:0] in_color_value,
  input  logic [POS_W-1:0] in_range_lo,
  input  logic [POS_W-1:0] in_range_hi,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [CNT_W-1:0] out_distinct_count,
  output logic             out_bad_range
);

  cmd_t cmd;
  logic cmd_valid, cmd_pop;
  res_t res, res_q;
  logic res_push, res_full, init_busy;
  logic [$bits(res_t)-1:0] res_dout;

  rdc_front #(
    .ARRAY_SIZE  (ARRAY_SIZE),
    .COLOR_COUNT (COLOR_COUNT)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_func        (in_func),
    .in_position    (in_position),
    .in_color_value (in_color_value),
    .in_range_lo    (in_range_lo),
    .in_range_hi    (in_range_hi),
    .init_busy      (init_busy),
    .cmd            (cmd),
    .cmd_valid      (cmd_valid),
    .cmd_pop        (cmd_pop)
  );

  rdc_back #(
    .ARRAY_SIZE  (ARRAY_SIZE),
    .COLOR_COUNT (COLOR_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .res       (res),
    .res_push  (res_push),
    .res_full  (res_full),
    .init_busy (init_busy)
  );

  rdc_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (res_dout),
    .empty (out_empty)
  );

  assign res_q              = res_t'(res_dout);
  assign out_distinct_count = res_q.count;
  assign out_bad_range      = res_q.bad;

endmodule
